// ===== rtl/core/drive_mode_sequencer_core_macros.svh =====
// -----------------------------------------------------------------------------
// Drive mode sequencer assertion macros
// Shared concurrent assertion helpers for the sequencer core.
// -----------------------------------------------------------------------------
`ifndef DRIVE_MODE_SEQUENCER_CORE_MACROS_SVH
`define DRIVE_MODE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define DMS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dms assertion failed");

// Condition in one cycle implies a consequence in the next.
`define DMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dms assertion failed");

`else

`define DMS_ASSERT(lbl, clk, rst, prop)
`define DMS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/dms_pkg.sv =====
// -----------------------------------------------------------------------------
// Drive mode sequencer package
// Types, codes and constants shared by the sequencer core files.
// -----------------------------------------------------------------------------
package dms_pkg;

   localparam int BRAKE_ADC_BITS_DEF = 12;
   localparam int BRAKE_THR_W        = 12;
   localparam int CSR_DATA_W         = 16;
   localparam int CSR_IDX_W          = 3;
   localparam int LIMIT_W            = 16;
   localparam int THROTTLE_W         = 16;
   localparam int NUM_PROFILES       = 4;
   localparam int PROFILE_W          = 2;

   // Dash button bit positions.
   localparam int BTN_UP_BIT   = 0;
   localparam int BTN_DOWN_BIT = 1;
   localparam int BTN_REV_BIT  = 2;

   localparam logic [2:0] BTN_NONE          = 3'b000;
   localparam logic [2:0] BTN_DOWN_ONLY     = 3'b010;
   localparam logic [2:0] BTN_PROFILE_CYCLE = 3'b110;

   typedef enum logic [2:0] {
      MODE_INIT    = 3'd0,
      MODE_SELECT  = 3'd1,
      MODE_RELEASE = 3'd2,
      MODE_FDELAY  = 3'd3,
      MODE_FWD     = 3'd4,
      MODE_RDELAY  = 3'd5,
      MODE_REV     = 3'd6,
      MODE_FAULT   = 3'd7
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMIT_SAFE       = 3'd0,
      CSR_LIMIT_ENDURANCE  = 3'd1,
      CSR_LIMIT_AUTOCROSS  = 3'd2,
      CSR_LIMIT_LUDICROUS  = 3'd3,
      CSR_BRAKE_ON_THR     = 3'd4,
      CSR_THROTTLE_IDLE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NUM_PROFILES-1:0][LIMIT_W-1:0] limit;
      logic [CSR_DATA_W-1:0]                brake_thr;
      logic [THROTTLE_W-1:0]                thr_idle;
   } cfg_type;

   typedef struct packed {
      mode_type             mode;
      logic [PROFILE_W-1:0] profile;
      logic [LIMIT_W-1:0]   limit;
      logic                 fwd_on;
      logic                 rev_on;
   } state_type;

   typedef struct packed {
      mode_type             mode;
      logic                 forward_switch;
      logic                 reverse_switch;
      logic [PROFILE_W-1:0] drive_profile;
      logic [LIMIT_W-1:0]   throttle_limit;
      logic                 start_forward_delay;
      logic                 start_reverse_delay;
      logic                 cancel_delay;
      logic                 clear_timer_done;
   } result_type;

endpackage

// ===== rtl/core/dms_req_if.sv =====
// -----------------------------------------------------------------------------
// Drive mode sequencer request channel
// Valid/ready channel carrying one evaluation tick of driver inputs.
// -----------------------------------------------------------------------------
interface dms_req_if #(
   parameter int BRAKE_BITS = dms_pkg::BRAKE_ADC_BITS_DEF
);
   import dms_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [2:0]                   dash_buttons;
   logic [BRAKE_BITS-1:0]        brake_level;
   logic signed [THROTTLE_W-1:0] throttle_level;
   logic                         forward_delay_done;
   logic                         reverse_delay_done;
   logic [2:0]                   fault_flags;

   modport source (
      output valid, dash_buttons, brake_level, throttle_level,
             forward_delay_done, reverse_delay_done, fault_flags,
      input  ready
   );

   modport sink (
      input  valid, dash_buttons, brake_level, throttle_level,
             forward_delay_done, reverse_delay_done, fault_flags,
      output ready
   );

endinterface

// ===== rtl/core/dms_rsp_if.sv =====
// -----------------------------------------------------------------------------
// Drive mode sequencer response channel
// Valid/ready channel carrying the mode, switches, limit and timer pulses.
// -----------------------------------------------------------------------------
interface dms_rsp_if;
   import dms_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [2:0]           mode;
   logic                 forward_switch;
   logic                 reverse_switch;
   logic [PROFILE_W-1:0] drive_profile;
   logic [LIMIT_W-1:0]   throttle_limit;
   logic                 start_forward_delay;
   logic                 start_reverse_delay;
   logic                 cancel_delay;
   logic                 clear_timer_done;

   modport source (
      output valid, mode, forward_switch, reverse_switch, drive_profile,
             throttle_limit, start_forward_delay, start_reverse_delay,
             cancel_delay, clear_timer_done,
      input  ready
   );

   modport sink (
      input  valid, mode, forward_switch, reverse_switch, drive_profile,
             throttle_limit, start_forward_delay, start_reverse_delay,
             cancel_delay, clear_timer_done,
      output ready
   );

endinterface

// ===== rtl/core/dms_csr.sv =====
// -----------------------------------------------------------------------------
// Drive mode sequencer configuration registers
// Holds the four profile limits and the two arming thresholds.
// -----------------------------------------------------------------------------
module dms_csr #(
   parameter int BRAKE_ADC_BITS = dms_pkg::BRAKE_ADC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dms_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output dms_pkg::cfg_type                 cfg
);
   import dms_pkg::*;

   logic [NUM_PROFILES-1:0][LIMIT_W-1:0] limit_ff, limit_in;
   logic [BRAKE_ADC_BITS-1:0]            brake_thr_ff, brake_thr_in;
   logic [THROTTLE_W-1:0]                thr_idle_ff, thr_idle_in;

   always_comb begin
      limit_in     = limit_ff;
      brake_thr_in = brake_thr_ff;
      thr_idle_in  = thr_idle_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LIMIT_SAFE:      limit_in[0]  = csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_ENDURANCE: limit_in[1]  = csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_AUTOCROSS: limit_in[2]  = csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_LUDICROUS: limit_in[3]  = csr_wdata[LIMIT_W-1:0];
            // The threshold register is twelve bits; it is then seen within the brake width.
            CSR_BRAKE_ON_THR:    brake_thr_in = BRAKE_ADC_BITS'(csr_wdata[BRAKE_THR_W-1:0]);
            CSR_THROTTLE_IDLE:   thr_idle_in  = csr_wdata[THROTTLE_W-1:0];
            default: begin
               // Writes to unused indices are dropped.
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         brake_thr_ff <= '0;
         thr_idle_ff  <= '0;
      end else begin
         limit_ff     <= limit_in;
         brake_thr_ff <= brake_thr_in;
         thr_idle_ff  <= thr_idle_in;
      end
   end

   assign cfg.limit     = limit_ff;
   assign cfg.brake_thr = CSR_DATA_W'(brake_thr_ff);
   assign cfg.thr_idle  = thr_idle_ff;

endmodule

// ===== rtl/core/dms_step.sv =====
// -----------------------------------------------------------------------------
// Drive mode sequencer step
// Mode state register and the single-tick transition logic.
// -----------------------------------------------------------------------------
`include "drive_mode_sequencer_core_macros.svh"

module dms_step #(
   parameter int BRAKE_ADC_BITS = dms_pkg::BRAKE_ADC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [2:0]                            dash_buttons,
   input  logic [BRAKE_ADC_BITS-1:0]             brake_level,
   input  logic signed [dms_pkg::THROTTLE_W-1:0] throttle_level,
   input  logic                                  forward_delay_done,
   input  logic                                  reverse_delay_done,
   input  logic [2:0]                            fault_flags,
   input  dms_pkg::cfg_type                      cfg,
   output dms_pkg::result_type                   result
);
   import dms_pkg::*;

   state_type            state_ff, state_in;
   mode_type             mode_cur;
   logic                 armed;
   logic                 btn_rev;
   logic [PROFILE_W-1:0] profile_next;
   logic                 sfwd, srev, cancel, clr;

   assign btn_rev      = dash_buttons[BTN_REV_BIT];
   assign profile_next = state_ff.profile + PROFILE_W'(1);

   // Forward may be armed only with the brake held and the throttle idle.
   assign armed = dash_buttons[BTN_UP_BIT] &&
                  (brake_level > cfg.brake_thr[BRAKE_ADC_BITS-1:0]) &&
                  ($signed(throttle_level) < $signed(cfg.thr_idle));

   always_comb begin
      // A fault flag overrides the held mode before the transition.
      mode_cur = (fault_flags != 3'b000) ? MODE_FAULT : state_ff.mode;
      state_in = state_ff;
      state_in.mode = mode_cur;
      sfwd   = 1'b0;
      srev   = 1'b0;
      cancel = 1'b0;
      clr    = 1'b0;
      case (mode_cur)
         MODE_INIT: begin
            state_in.limit = cfg.limit[state_ff.profile];
            state_in.mode  = MODE_SELECT;
         end
         MODE_SELECT: begin
            state_in.fwd_on = 1'b0;
            state_in.rev_on = 1'b0;
            if (dash_buttons == BTN_PROFILE_CYCLE) begin
               state_in.profile = profile_next;
               state_in.limit   = cfg.limit[profile_next];
               state_in.mode    = MODE_RELEASE;
            end else if (armed) begin
               sfwd          = 1'b1;
               state_in.mode = MODE_FDELAY;
            end
         end
         MODE_RELEASE: begin
            if (dash_buttons == BTN_NONE || dash_buttons == BTN_DOWN_ONLY) begin
               state_in.mode = MODE_SELECT;
            end
         end
         MODE_FDELAY: begin
            if (armed && forward_delay_done) begin
               clr           = 1'b1;
               state_in.mode = MODE_FWD;
            end else if (!armed) begin
               state_in.mode = MODE_SELECT;
            end
         end
         MODE_FWD: begin
            state_in.fwd_on = 1'b1;
            state_in.rev_on = 1'b0;
            if (dash_buttons[BTN_DOWN_BIT]) begin
               state_in.mode = MODE_SELECT;
            end else if (btn_rev) begin
               srev          = 1'b1;
               state_in.mode = MODE_RDELAY;
            end
         end
         MODE_RDELAY: begin
            if (btn_rev && reverse_delay_done) begin
               clr           = 1'b1;
               state_in.mode = MODE_REV;
            end else if (!btn_rev) begin
               cancel        = 1'b1;
               state_in.mode = MODE_FWD;
            end
         end
         MODE_REV: begin
            state_in.fwd_on = 1'b0;
            state_in.rev_on = 1'b1;
            if (!btn_rev) begin
               cancel        = 1'b1;
               state_in.mode = MODE_FWD;
            end
         end
         default: begin
            // Fault mode is latched until reset with both switches open.
            state_in.fwd_on = 1'b0;
            state_in.rev_on = 1'b0;
            state_in.mode   = MODE_FAULT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= MODE_INIT;
         state_ff.profile <= '0;
         state_ff.limit   <= '0;
         state_ff.fwd_on  <= 1'b0;
         state_ff.rev_on  <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign result.mode                = state_in.mode;
   assign result.forward_switch      = state_in.fwd_on;
   assign result.reverse_switch      = state_in.rev_on;
   assign result.drive_profile       = state_in.profile;
   assign result.throttle_limit      = state_in.limit;
   assign result.start_forward_delay = sfwd;
   assign result.start_reverse_delay = srev;
   assign result.cancel_delay        = cancel;
   assign result.clear_timer_done    = clr;

   `DMS_ASSERT_NEXT(a_fault_latched, clock, reset, state_ff.mode == MODE_FAULT, state_ff.mode == MODE_FAULT)
   `DMS_ASSERT(a_switch_exclusive, clock, reset, !(state_ff.fwd_on && state_ff.rev_on))
   `DMS_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(state_ff))

endmodule

// ===== rtl/core/drive_mode_sequencer_core.sv =====
// -----------------------------------------------------------------------------
// Drive mode sequencer core
// Vehicle drive mode state machine evaluated once per request transaction.
// -----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Carries
//  req_ch    in         valid/ready   buttons, brake, throttle, timer done, faults
//  rsp_ch    out        valid/ready   mode, switches, profile, limit, timer pulses
//  csr_*     in         write enable  profile limits and arming thresholds
//
// One transaction per cycle is sustained while rsp_ch is ready; a request is
// registered, evaluated by the step logic and its response registered.
// The input register accepts a new request whenever it is empty or moving on.
// A stalled response holds the step; the state advances only when it moves.
// Reset is synchronous and clears the mode, profile, limit, configuration and valid flags.
// -----------------------------------------------------------------------------
`include "drive_mode_sequencer_core_macros.svh"

module drive_mode_sequencer_core #(
   parameter int BRAKE_ADC_BITS = dms_pkg::BRAKE_ADC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dms_req_if.sink                        req_ch,
   dms_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [dms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dms_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dms_pkg::*;

   cfg_type                      cfg;
   result_type                   step_result;
   result_type                   out_ff;
   logic                         out_valid_ff, out_valid_in;
   logic                         in_valid_ff, in_valid_in;
   logic                         advance;
   logic                         req_take;
   logic [2:0]                   dash_ff;
   logic [BRAKE_ADC_BITS-1:0]    brake_ff;
   logic signed [THROTTLE_W-1:0] throttle_ff;
   logic                         fdone_ff;
   logic                         rdone_ff;
   logic [2:0]                   faults_ff;

   // The step fires when the response register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dash_ff     <= req_ch.dash_buttons;
         brake_ff    <= req_ch.brake_level;
         throttle_ff <= req_ch.throttle_level;
         fdone_ff    <= req_ch.forward_delay_done;
         rdone_ff    <= req_ch.reverse_delay_done;
         faults_ff   <= req_ch.fault_flags;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   dms_csr #(
      .BRAKE_ADC_BITS (BRAKE_ADC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dms_step #(
      .BRAKE_ADC_BITS (BRAKE_ADC_BITS)
   ) u_step (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .dash_buttons       (dash_ff),
      .brake_level        (brake_ff),
      .throttle_level     (throttle_ff),
      .forward_delay_done (fdone_ff),
      .reverse_delay_done (rdone_ff),
      .fault_flags        (faults_ff),
      .cfg                (cfg),
      .result             (step_result)
   );

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.mode                = out_ff.mode;
   assign rsp_ch.forward_switch      = out_ff.forward_switch;
   assign rsp_ch.reverse_switch      = out_ff.reverse_switch;
   assign rsp_ch.drive_profile       = out_ff.drive_profile;
   assign rsp_ch.throttle_limit      = out_ff.throttle_limit;
   assign rsp_ch.start_forward_delay = out_ff.start_forward_delay;
   assign rsp_ch.start_reverse_delay = out_ff.start_reverse_delay;
   assign rsp_ch.cancel_delay        = out_ff.cancel_delay;
   assign rsp_ch.clear_timer_done    = out_ff.clear_timer_done;

   `DMS_ASSERT_NEXT(a_pending_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `DMS_ASSERT(a_one_pulse, clock, reset, !out_valid_ff || $onehot0({out_ff.start_forward_delay, out_ff.start_reverse_delay, out_ff.cancel_delay, out_ff.clear_timer_done}))
   `DMS_ASSERT_NEXT(a_step_fills_out, clock, reset, advance, out_valid_ff)

endmodule
